// ===== sv/tarw_pkg.sv =====
// Shared types, codes and helper functions for the tar header walker.
`default_nettype none

package tarw_pkg;

    // Default offset width
    localparam int TARW_ADDR_BITS = 40;

    // Result queue depth (entries of up to two results each)
    localparam int TARW_QDEPTH = 4;

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int SIZE_W  = 32;
    localparam int CLASS_W = 4;
    localparam int ERR_W   = 3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_MAGIC    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BASE256  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DIGIT    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TOO_BIG  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_TRUNC    = 3'd5;
    localparam logic [ERR_W-1:0] ERR_NOT_MULT = 3'd6;
    localparam logic [ERR_W-1:0] ERR_SHORT    = 3'd7;

    // Payload classes
    localparam logic [CLASS_W-1:0] CLS_PLAIN = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_PNG   = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_JPEG  = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_ZIP   = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_PDF   = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_GZIP  = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_BZ2   = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_XZ    = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_ZSTD  = 4'd8;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } tarw_qstat_t;

    // "ustar" magic, indexed from header byte 257
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Payload class from the first sniffed bytes
    function automatic logic [CLASS_W-1:0] classify(input logic [63:0] w,
                                                     input logic [32:0] sz,
                                                     input logic        regular);
        logic [CLASS_W-1:0] c;
        c = CLS_PLAIN;
        if (!regular || sz == 33'd0) begin
            c = CLS_PLAIN;
        end else if (sz >= 33'd8 && w == 64'h0A1A0A0D474E5089) begin
            c = CLS_PNG;
        end else if (sz >= 33'd4 && w[23:0] == 24'hFFD8FF) begin
            c = CLS_JPEG;
        end else if (sz >= 33'd22 && w[15:0] == 16'h4B50) begin
            c = CLS_ZIP;
        end else if (sz >= 33'd32 && w[39:0] == 40'h2D46445025) begin
            c = CLS_PDF;
        end else if (sz >= 33'd18 && w[23:0] == 24'h088B1F) begin
            c = CLS_GZIP;
        end else if (sz >= 33'd14 && w[23:0] == 24'h685A42 &&
                     w[31:24] >= 8'h31 && w[31:24] <= 8'h39) begin
            c = CLS_BZ2;
        end else if (sz >= 33'd12 && w[47:0] == 48'h005A587A37FD) begin
            c = CLS_XZ;
        end else if (sz >= 33'd8 && w[31:0] == 32'hFD2FB528) begin
            c = CLS_ZSTD;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tarw_front.sv =====
// Front end: per-byte header walk, octal size parse, payload tracking, result build.
`default_nettype none

module tarw_front
    import tarw_pkg::*;
#(
    parameter int ADDR_BITS = TARW_ADDR_BITS,
    parameter int RW        = ADDR_BITS + 42,
    parameter int QW        = 2 * (RW + 1) + 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output logic               in_ready,
    input  tarw_qstat_t        qstat,
    output logic               push,
    output logic [QW-1:0]      push_entry
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRAILER,
        PH_DEAD
    } phase_t;

    typedef enum logic [1:0] {
        OCT_RUN,
        OCT_STOP,
        OCT_B256,
        OCT_BAD
    } oct_t;

    phase_t                 phase_reg, phase_next;
    logic [8:0]             pos_reg, pos_next;
    logic [ADDR_BITS-1:0]   off_reg, off_next;
    logic [ADDR_BITS-1:0]   hs_reg, hs_next;
    logic                   hnz_reg, hnz_next;
    logic                   magic_reg, magic_next;
    logic [32:0]            acc_reg, acc_next;
    oct_t                   oct_reg, oct_next;
    logic                   regf_reg, regf_next;
    logic [32:0]            rem_reg, rem_next;
    logic [63:0]            win_reg, win_next;
    logic [3:0]             scnt_reg, scnt_next;
    logic [ADDR_BITS-1:0]   tail_reg, tail_next;

    logic                   take;
    logic [ADDR_BITS:0]     len;
    logic [RW:0]            r0, r1;
    logic [1:0]             n;

    // Record: {last, err, class, regular, size, offset, kind}
    function automatic logic [RW:0] mk(input logic [KIND_W-1:0]    kind,
                                       input logic [ADDR_BITS-1:0] off,
                                       input logic [SIZE_W-1:0]    size,
                                       input logic                 regular,
                                       input logic [CLASS_W-1:0]   cls,
                                       input logic [ERR_W-1:0]     err);
        return {1'b0, err, cls, regular, size, off, kind};
    endfunction

    assign in_ready = !qstat.full;
    assign take     = in_valid && in_ready;
    assign len      = {1'b0, off_reg} + {{ADDR_BITS{1'b0}}, 1'b1};

    // Per-byte state update and result generation
    always_comb begin
        logic [RW:0] rec;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        off_next   = off_reg;
        hs_next    = hs_reg;
        hnz_next   = hnz_reg;
        magic_next = magic_reg;
        acc_next   = acc_reg;
        oct_next   = oct_reg;
        regf_next  = regf_reg;
        rem_next   = rem_reg;
        win_next   = win_reg;
        scnt_next  = scnt_reg;
        tail_next  = tail_reg;
        r0  = '0;
        r1  = '0;
        n   = 2'd0;
        rec = '0;

        if (take && phase_reg != PH_DEAD) begin
            pos_next = pos_reg + 9'd1;
            off_next = off_reg + {{(ADDR_BITS-1){1'b0}}, 1'b1};

            if (in_last && len < (ADDR_BITS+1)'(1024)) begin
                r0 = mk(KIND_ERROR, '0, '0, 1'b0, CLS_PLAIN, ERR_SHORT);
                n  = 2'd1;
                phase_next = PH_DEAD;
            end else if (in_last && pos_reg != 9'd511) begin
                r0 = mk(KIND_ERROR, '0, '0, 1'b0, CLS_PLAIN, ERR_NOT_MULT);
                n  = 2'd1;
                phase_next = PH_DEAD;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        // new header block: clear per-entry state
                        if (pos_reg == 9'd0) begin
                            hs_next    = off_reg;
                            hnz_next   = 1'b0;
                            magic_next = 1'b1;
                            acc_next   = '0;
                            oct_next   = OCT_RUN;
                            regf_next  = 1'b0;
                            win_next   = '0;
                            scnt_next  = '0;
                        end
                        if (in_byte != 8'h00) hnz_next = 1'b1;
                        if (pos_reg inside {[9'd257:9'd261]} &&
                            in_byte != magic_char(3'(pos_reg - 9'd257)))
                            magic_next = 1'b0;
                        // octal size field
                        if (pos_reg == 9'd124 && in_byte[7]) begin
                            oct_next = OCT_B256;
                        end else if (pos_reg inside {[9'd124:9'd134]} && oct_next == OCT_RUN) begin
                            if (in_byte == 8'h00 || in_byte == 8'h20)
                                oct_next = OCT_STOP;
                            else if (in_byte < 8'h30 || in_byte > 8'h37)
                                oct_next = OCT_BAD;
                            else
                                acc_next = {acc_next[29:0], in_byte[2:0]};
                        end
                        if (pos_reg == 9'd156)
                            regf_next = (in_byte == 8'h30 || in_byte == 8'h00);
                        // end of header block: decide
                        if (pos_reg == 9'd511) begin
                            if (!hnz_next) begin
                                if (hs_reg == '0) begin
                                    r0 = mk(KIND_ERROR, '0, '0, 1'b0, CLS_PLAIN, ERR_MAGIC);
                                    n  = 2'd1;
                                    phase_next = PH_DEAD;
                                end else begin
                                    tail_next  = hs_reg;
                                    phase_next = PH_TRAILER;
                                end
                            end else if (!magic_next) begin
                                r0 = mk(KIND_ERROR, '0, '0, 1'b0, CLS_PLAIN, ERR_MAGIC);
                                n  = 2'd1;
                                phase_next = PH_DEAD;
                            end else if (oct_next == OCT_B256) begin
                                r0 = mk(KIND_ERROR, '0, '0, 1'b0, CLS_PLAIN, ERR_BASE256);
                                n  = 2'd1;
                                phase_next = PH_DEAD;
                            end else if (oct_next == OCT_BAD) begin
                                r0 = mk(KIND_ERROR, '0, '0, 1'b0, CLS_PLAIN, ERR_DIGIT);
                                n  = 2'd1;
                                phase_next = PH_DEAD;
                            end else if (acc_next[32]) begin
                                r0 = mk(KIND_ERROR, '0, '0, 1'b0, CLS_PLAIN, ERR_TOO_BIG);
                                n  = 2'd1;
                                phase_next = PH_DEAD;
                            end else if (acc_next == '0) begin
                                r0 = mk(KIND_ENTRY, hs_reg, '0, regf_next, CLS_PLAIN, ERR_NONE);
                                n  = 2'd1;
                            end else begin
                                // round up to whole blocks
                                rem_next = {acc_next[32:9] + {23'd0, |acc_next[8:0]}, 9'd0};
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        if (!scnt_reg[3]) begin
                            win_next[8*scnt_reg[2:0] +: 8] = in_byte;
                            scnt_next = scnt_reg + 4'd1;
                        end
                        rem_next = rem_reg - 33'd1;
                        if (rem_next == '0) begin
                            r0 = mk(KIND_ENTRY, hs_reg, acc_reg[SIZE_W-1:0], regf_reg,
                                    classify(win_next, acc_reg, regf_reg), ERR_NONE);
                            n  = 2'd1;
                            phase_next = PH_HEADER;
                        end
                    end
                    default: begin
                    end
                endcase

                // archive end, or truncation error, on the final byte
                if (in_last && phase_next != PH_DEAD) begin
                    if (phase_next == PH_PAYLOAD) begin
                        rec = mk(KIND_ERROR, '0, '0, 1'b0, CLS_PLAIN, ERR_TRUNC);
                        phase_next = PH_DEAD;
                    end else begin
                        rec = mk(KIND_END,
                                 (phase_next == PH_TRAILER) ? tail_next : len[ADDR_BITS-1:0],
                                 '0, 1'b0, CLS_PLAIN, ERR_NONE);
                    end
                    if (n == 2'd0) r0 = rec;
                    else           r1 = rec;
                    n = n + 2'd1;
                end
            end

            // flag the final result of this beat
            if (n == 2'd2)      r1[RW] = 1'b1;
            else if (n == 2'd1) r0[RW] = 1'b1;
        end
    end

    assign push       = (n != 2'd0);
    assign push_entry = {n, r1, r0};

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            off_reg   <= '0;
            hs_reg    <= '0;
            hnz_reg   <= 1'b0;
            magic_reg <= 1'b1;
            acc_reg   <= '0;
            oct_reg   <= OCT_RUN;
            regf_reg  <= 1'b0;
            rem_reg   <= '0;
            win_reg   <= '0;
            scnt_reg  <= '0;
            tail_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            hs_reg    <= hs_next;
            hnz_reg   <= hnz_next;
            magic_reg <= magic_next;
            acc_reg   <= acc_next;
            oct_reg   <= oct_next;
            regf_reg  <= regf_next;
            rem_reg   <= rem_next;
            win_reg   <= win_next;
            scnt_reg  <= scnt_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tarw_queue.sv =====
// Small result queue between the front end and the output stage.
`default_nettype none

module tarw_queue
    import tarw_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = TARW_QDEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic [W-1:0]      head,
    output tarw_qstat_t       qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign head        = mem[rd_reg];
    assign qstat.empty = (cnt_reg == '0);
    assign qstat.full  = (cnt_reg == CW'(DEPTH));

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop)      cnt_next = cnt_reg + CW'(1);
        else if (!push && pop) cnt_next = cnt_reg - CW'(1);
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (pop)  rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full && !pop |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.empty |-> !pop)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== sv/tarw_back.sv =====
// Output stage: unpacks queue entries into single result beats.
`default_nettype none

module tarw_back
    import tarw_pkg::*;
#(
    parameter int ADDR_BITS = TARW_ADDR_BITS,
    parameter int RW        = ADDR_BITS + 42,
    parameter int QW        = 2 * (RW + 1) + 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [QW-1:0] head,
    input  tarw_qstat_t        qstat,
    output logic               pop,
    output logic               out_valid,
    output logic [RW:0]        out_rec,
    input  wire logic          out_ready
);

    logic          ov_reg, ov_next;
    logic [RW:0]   orec_reg, orec_next;
    logic          sv_reg, sv_next;
    logic [RW:0]   srec_reg, srec_next;
    logic          load;

    assign load = !ov_reg || out_ready;

    // Pick the next beat: held second result first, then queue head
    always_comb begin
        ov_next   = ov_reg;
        orec_next = orec_reg;
        sv_next   = sv_reg;
        srec_next = srec_reg;
        pop       = 1'b0;
        if (load) begin
            if (sv_reg) begin
                ov_next   = 1'b1;
                orec_next = srec_reg;
                sv_next   = 1'b0;
            end else if (!qstat.empty) begin
                ov_next   = 1'b1;
                orec_next = head[RW:0];
                srec_next = head[2*RW+1:RW+1];
                sv_next   = (head[QW-1:QW-2] == 2'd2);
                pop       = 1'b1;
            end else begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end else begin
            ov_reg <= ov_next;
            sv_reg <= sv_next;
        end
        orec_reg <= orec_next;
        srec_reg <= srec_next;
    end

    assign out_valid = ov_reg;
    assign out_rec   = orec_reg;

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg |-> ov_reg)
        else $error("second result held without a beat in the output register");

    a_no_pop_with_second: assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg |-> !pop)
        else $error("queue popped while a second result is pending");

    a_second_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg |-> !orec_reg[RW])
        else $error("first of a pair flagged as last");

endmodule

`default_nettype wire

// ===== sv/tar_header_walker_core.sv =====
// Top level of the tar header walker: stream ports, front end, queue, output stage.
`default_nettype none

// Channel | Dir | Beat holds
// s_      | in  | tdata: data_byte[7:0]; tlast: last_byte
// m_      | out | tdata: result_kind, entry_offset, entry_size, regular_entry,
//         |     |        payload_class, error_code (low to high); tlast: last_of_run
//
// One archive byte is taken per cycle; the per-byte header/payload update is
// computed combinationally in the front end. Each byte gives zero to two results,
// which go into a 4-entry queue and leave one beat per cycle from the output
// register while m_tready is high. Input stalls only when the queue is full.
// Reset is synchronous and active low; after an error the block stays silent until reset.

module tar_header_walker_core
    import tarw_pkg::*;
#(
    parameter int ADDR_BITS = TARW_ADDR_BITS
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic [7:0]                              s_tdata,  // data_byte
    input  wire logic                                    s_tlast,  // last_byte
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // result_kind, entry_offset, entry_size, regular_entry, payload_class, error_code
    output logic [((ADDR_BITS + 42 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                         m_tlast   // last_of_run
);

    localparam int RW  = ADDR_BITS + 42;
    localparam int QW  = 2 * (RW + 1) + 2;
    localparam int TDW = ((ADDR_BITS + 42 + 7) / 8) * 8;

    tarw_qstat_t   qstat;
    logic          push, pop;
    logic [QW-1:0] push_entry, head;
    logic [RW:0]   out_rec;

    tarw_front #(.ADDR_BITS(ADDR_BITS), .RW(RW), .QW(QW)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    tarw_queue #(.W(QW), .DEPTH(TARW_QDEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    tarw_back #(.ADDR_BITS(ADDR_BITS), .RW(RW), .QW(QW)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_rec   (out_rec),
        .out_ready (m_tready)
    );

    assign m_tdata = TDW'(out_rec[RW-1:0]);
    assign m_tlast = out_rec[RW];

endmodule

`default_nettype wire
